### rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Shared codes, match patterns and the saturating decimal digit step.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int ACC_W = 31;
	localparam logic [ACC_W-1:0] SAT_MAX = {ACC_W{1'b1}};

	// Request kinds on the input tuser field.
	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;
	localparam logic [1:0] MODE_ERROR = 2'd3;

	// Parser phase, also reported as header_state.
	localparam logic [1:0] PH_READ       = 2'd0;
	localparam logic [1:0] PH_DONE       = 2'd1;
	localparam logic [1:0] PH_STATUS_ERR = 2'd2;
	localparam logic [1:0] PH_RECV_ERR   = 2'd3;

	// Status line scan steps.
	localparam logic [2:0] SS_MATCH  = 3'd0;
	localparam logic [2:0] SS_SKIP   = 3'd1;
	localparam logic [2:0] SS_BLANK  = 3'd2;
	localparam logic [2:0] SS_DIGITS = 3'd3;
	localparam logic [2:0] SS_DONE   = 3'd4;

	// Length line scan steps.
	localparam logic [1:0] LS_MATCH  = 2'd0;
	localparam logic [1:0] LS_BLANK  = 2'd1;
	localparam logic [1:0] LS_DIGITS = 2'd2;
	localparam logic [1:0] LS_DONE   = 2'd3;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	localparam logic [ACC_W-1:0] STATUS_OK = 31'd200;

	localparam logic [2:0] STATUS_PAT_LEN = 3'd7;
	localparam logic [3:0] LENGTH_PAT_LEN = 4'd15;

	// Patterns padded by one unused entry so every position code indexes in range.
	localparam logic [7:0] STATUS_PAT [8] = '{
		"H", "T", "T", "P", "/", "1", ".", 8'h00
	};
	localparam logic [7:0] LENGTH_PAT [16] = '{
		"C", "O", "N", "T", "E", "N", "T", "-",
		"L", "E", "N", "G", "T", "H", ":", 8'h00
	};

	// acc * 10 + d, clamped to the largest 31-bit value.
	function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
		input logic [3:0] d);
		logic [ACC_W+3:0] v;
		v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACC_W{1'b0}}, d};
		return (v > {4'b0000, SAT_MAX}) ? SAT_MAX : v[ACC_W-1:0];
	endfunction

endpackage

### rtl/http_response_header_parser.sv
// Each request passes the input register, then the result register, to m_axis.
// Throughput: one request per cycle unless m_axis stalls; one state update per byte.
// Each result holds until taken; a stalled output backs up through one input register.
// Reset (arst_n low) clears the phase to reading headers and both latched numbers to zero.
// ----------------------------------------------------------------------------
// HTTP response header parser
// Splits response bytes into header lines, picks out the status code and the
// content length, and passes body bytes through once the headers end.
// ----------------------------------------------------------------------------
module http_response_header_parser
	import hrhp_pkg::*;
#(
	parameter int LINE_LIMIT = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic [1:0]  s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// header_state[1:0], status_code[32:2], content_length[63:33], body_byte[71:64]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tuser    // body_valid
);

	localparam int LEN_W = $clog2(LINE_LIMIT + 1);
	localparam logic [LEN_W-1:0] LIMIT = LEN_W'(LINE_LIMIT);

	// Input stage
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] byte_s1;

	// Parser state
	logic [1:0]       phase_q;
	logic [LEN_W-1:0] line_len_q;
	logic             first_cr_q;
	logic             nul_q;
	logic [2:0]       status_pos_q;
	logic [3:0]       length_pos_q;
	logic [2:0]       status_step_q;
	logic [1:0]       length_step_q;
	logic [ACC_W-1:0] status_acc_q;
	logic [ACC_W-1:0] length_acc_q;
	logic [ACC_W-1:0] status_lat_q;
	logic [ACC_W-1:0] length_lat_q;

	// Result stage
	logic             valid_s2;
	logic [1:0]       state_s2;
	logic [ACC_W-1:0] status_s2;
	logic [ACC_W-1:0] length_s2;
	logic             body_valid_s2;
	logic [7:0]       body_byte_s2;

	logic out_free;
	logic advance;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// Next-state logic for one byte or event
	logic [1:0]       phase_n;
	logic [LEN_W-1:0] line_len_n;
	logic             first_cr_n;
	logic             nul_n;
	logic [2:0]       status_pos_n;
	logic [3:0]       length_pos_n;
	logic [2:0]       status_step_n;
	logic [1:0]       length_step_n;
	logic [ACC_W-1:0] status_acc_n;
	logic [ACC_W-1:0] length_acc_n;
	logic [ACC_W-1:0] status_lat_n;
	logic [ACC_W-1:0] length_lat_n;
	logic             body;
	logic             clear_line;
	logic [7:0]       uc;
	logic             is_digit;
	logic             is_blank;

	always_comb begin
		is_digit = (byte_s1 >= "0") && (byte_s1 <= "9");
		is_blank = (byte_s1 == CHAR_SP) || (byte_s1 == CHAR_TAB);
		uc = ((byte_s1 >= "a") && (byte_s1 <= "z")) ? (byte_s1 & 8'hDF) : byte_s1;

		phase_n       = phase_q;
		line_len_n    = line_len_q;
		first_cr_n    = first_cr_q;
		nul_n         = nul_q;
		status_pos_n  = status_pos_q;
		length_pos_n  = length_pos_q;
		status_step_n = status_step_q;
		length_step_n = length_step_q;
		status_acc_n  = status_acc_q;
		length_acc_n  = length_acc_q;
		status_lat_n  = status_lat_q;
		length_lat_n  = length_lat_q;
		body          = 1'b0;
		clear_line    = 1'b0;

		unique case (mode_s1)
			MODE_START: begin
				phase_n      = PH_READ;
				status_lat_n = '0;
				length_lat_n = '0;
				clear_line   = 1'b1;
			end
			MODE_CLOSE: begin
				if (phase_q == PH_READ) begin
					phase_n    = PH_DONE;
					clear_line = 1'b1;
				end
			end
			MODE_ERROR: begin
				if (phase_q == PH_READ) begin
					phase_n    = PH_RECV_ERR;
					clear_line = 1'b1;
				end
			end
			default: begin
				if (phase_q == PH_DONE) begin
					body = 1'b1;
				end else if (phase_q == PH_READ) begin
					if (line_len_q == '0 && byte_s1 == CHAR_CR) begin
						first_cr_n = 1'b1;
					end
					line_len_n = line_len_q + 1'b1;
					if (byte_s1 == CHAR_NUL) begin
						nul_n = 1'b1;
					end

					if (!nul_n) begin
						unique case (status_step_q)
							SS_MATCH: begin
								if (uc == STATUS_PAT[status_pos_q]) begin
									status_pos_n = status_pos_q + 1'b1;
								end else begin
									status_pos_n = (uc == "H") ? 3'd1 : 3'd0;
								end
								if (status_pos_n == STATUS_PAT_LEN) begin
									status_step_n = SS_SKIP;
								end
							end
							SS_SKIP: status_step_n = SS_BLANK;
							SS_BLANK, SS_DIGITS: begin
								if (!(status_step_q == SS_BLANK && is_blank)) begin
									if (is_digit) begin
										status_acc_n  = add_digit(status_acc_q, byte_s1[3:0]);
										status_step_n = SS_DIGITS;
									end else begin
										status_step_n = SS_DONE;
									end
								end
							end
							default: ;
						endcase

						unique case (length_step_q)
							LS_MATCH: begin
								if (uc == LENGTH_PAT[length_pos_q]) begin
									length_pos_n = length_pos_q + 1'b1;
								end else begin
									length_pos_n = (uc == "C") ? 4'd1 : 4'd0;
								end
								if (length_pos_n == LENGTH_PAT_LEN) begin
									length_step_n = LS_BLANK;
								end
							end
							LS_BLANK, LS_DIGITS: begin
								if (!(length_step_q == LS_BLANK && is_blank)) begin
									if (is_digit) begin
										length_acc_n  = add_digit(length_acc_q, byte_s1[3:0]);
										length_step_n = LS_DIGITS;
									end else begin
										length_step_n = LS_DONE;
									end
								end
							end
							default: ;
						endcase
					end

					// End of line: a lone CR line closes the headers, anything else latches
					// whatever numbers the line carried, the length only if the status is not in error.
					if (byte_s1 == CHAR_LF || line_len_n >= LIMIT) begin
						clear_line = 1'b1;
						if (line_len_n == LEN_W'(2) && first_cr_n) begin
							phase_n = PH_DONE;
						end else begin
							if (status_step_n != SS_MATCH) begin
								status_lat_n = status_acc_n;
								if (status_acc_n != '0 && status_acc_n != STATUS_OK) begin
									phase_n = PH_STATUS_ERR;
								end
							end
							if (phase_n == PH_READ && length_step_n != LS_MATCH) begin
								length_lat_n = length_acc_n;
							end
						end
					end
				end
			end
		endcase

		if (clear_line) begin
			line_len_n    = '0;
			first_cr_n    = 1'b0;
			nul_n         = 1'b0;
			status_pos_n  = '0;
			length_pos_n  = '0;
			status_step_n = SS_MATCH;
			length_step_n = LS_MATCH;
			status_acc_n  = '0;
			length_acc_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_READ;
			line_len_q    <= '0;
			first_cr_q    <= 1'b0;
			nul_q         <= 1'b0;
			status_pos_q  <= '0;
			length_pos_q  <= '0;
			status_step_q <= SS_MATCH;
			length_step_q <= LS_MATCH;
			status_acc_q  <= '0;
			length_acc_q  <= '0;
			status_lat_q  <= '0;
			length_lat_q  <= '0;
		end else if (advance) begin
			phase_q       <= phase_n;
			line_len_q    <= line_len_n;
			first_cr_q    <= first_cr_n;
			nul_q         <= nul_n;
			status_pos_q  <= status_pos_n;
			length_pos_q  <= length_pos_n;
			status_step_q <= status_step_n;
			length_step_q <= length_step_n;
			status_acc_q  <= status_acc_n;
			length_acc_q  <= length_acc_n;
			status_lat_q  <= status_lat_n;
			length_lat_q  <= length_lat_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s2      <= phase_n;
			status_s2     <= status_lat_n;
			length_s2     <= length_lat_n;
			body_valid_s2 <= body;
			body_byte_s2  <= body ? byte_s1 : 8'h00;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {body_byte_s2, length_s2, status_s2, state_s2};
	assign m_axis_tuser  = body_valid_s2;

	// A body byte only ever leaves while the headers are done.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == PH_DONE)
		else $error("body byte reported outside the done phase");

	// A line is ended when it reaches the limit, so the stored length stays below it.
	assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q < LIMIT)
		else $error("line length reached the limit without ending the line");

	// Once past the match step, the match position stays at the pattern end.
	assert property (@(posedge clk) disable iff (!arst_n)
		status_step_q != SS_MATCH |-> status_pos_q == STATUS_PAT_LEN)
		else $error("status scan left the match step early");

	assert property (@(posedge clk) disable iff (!arst_n)
		length_step_q != LS_MATCH |-> length_pos_q == LENGTH_PAT_LEN)
		else $error("length scan left the match step early");

	// Leaving the header phase always discards the partial line.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_READ |-> line_len_q == '0 && status_acc_q == '0)
		else $error("line state left over after the headers ended");

endmodule
